@@ rtl/core/mts_pkg.sv @@
// Shared types and constants for the minimum-tracking stack.
`timescale 1ns / 1ps

package mts_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic signed [31:0] MIN_EMPTY = 32'sh7FFF_FFFF;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] top_word;
        logic signed [31:0] min_word;
        logic               empty_flag;
        logic               full_flag;
        logic               dropped;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TOP,
        ST_SCAN,
        ST_SCAN_END,
        ST_RESULT
    } t_state;

endpackage

@@ rtl/core/mts_word_mem.sv @@
// Word store: single write port, single registered read port.
`timescale 1ns / 1ps

module mts_word_mem
    import mts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [ADDR_W-1:0]        i_wr_addr,
    input  logic signed [31:0]       i_wr_data,
    input  logic [ADDR_W-1:0]        i_rd_addr,
    output logic signed [31:0]       o_rd_data
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/mts_min_unit.sv @@
// Shared signed compare unit: passes on the lesser of two words.
`timescale 1ns / 1ps

module mts_min_unit
    import mts_pkg::*;
(
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_lesser
);

    assign o_lesser = (i_a < i_b) ? i_a : i_b;

endmodule

@@ rtl/core/min_tracking_stack.sv @@
// Minimum-tracking stack: top level with sequencer and result register.
// Sequence from input transfer to result: push, query and dropped items go from idle through
// execute to result; a pop that leaves words also reads the new top word, and a pop that removes
// the minimum then rescans the n words left for it; the rescan reads one word per cycle.
// One item at a time: the next input is taken once the result is in the output register.
// Reset (synchronous, active low) empties the stack; the word store itself is not cleared.
`timescale 1ns / 1ps

module min_tracking_stack
    import mts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_state             r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic signed [31:0] r_value, n_value;
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [31:0] r_min, n_min;
    logic signed [31:0] r_top, n_top;
    logic               r_drop, n_drop;
    logic               r_scan, n_scan;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic signed [31:0] r_acc, n_acc;
    t_out               r_out, n_out;
    logic               r_out_vld, n_out_vld;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic signed [31:0] rd_data;
    logic signed [31:0] cmp_a, cmp_b, lesser;
    logic               full;
    logic [ADDR_W-1:0]  last_addr;

    mts_word_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mts_min_unit u_min (
        .i_a      (cmp_a),
        .i_b      (cmp_b),
        .o_lesser (lesser)
    );

    assign full      = (r_count == CNT_W'(DEPTH));
    assign last_addr = ADDR_W'(r_count - CNT_W'(1));
    assign wr_addr   = r_count[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_min     <= MIN_EMPTY;
            r_top     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_min     <= n_min;
            r_top     <= n_top;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_value   <= n_value;
        r_drop    <= n_drop;
        r_scan    <= n_scan;
        r_idx     <= n_idx;
        r_cmp_vld <= n_cmp_vld;
        r_acc     <= n_acc;
        r_out     <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_value   = r_value;
        n_count   = r_count;
        n_min     = r_min;
        n_top     = r_top;
        n_drop    = r_drop;
        n_scan    = r_scan;
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        n_acc     = r_acc;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        wr_en     = 1'b0;
        rd_addr   = r_idx;
        cmp_a     = r_value;
        cmp_b     = r_min;

        // drop the result once it has been taken
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_in_data.mode;
                    n_value = i_in_data.value;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_drop  = 1'b0;
                n_state = ST_RESULT;
                case (r_mode)
                    MODE_PUSH: begin
                        if (full) begin
                            n_drop = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_top   = r_value;
                            n_min   = lesser;
                        end
                    end
                    MODE_POP: begin
                        if (r_count == '0) begin
                            n_drop = 1'b1;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_scan  = (r_top == r_min);
                            if (r_count == CNT_W'(1)) begin
                                n_top = '0;
                                n_min = MIN_EMPTY;
                            end else begin
                                // fetch the word beneath the one being removed
                                rd_addr = ADDR_W'(r_count - CNT_W'(2));
                                n_acc   = MIN_EMPTY;
                                n_idx   = '0;
                                n_state = ST_TOP;
                            end
                        end
                    end
                    default: begin
                        n_drop = 1'b0;
                    end
                endcase
            end
            ST_TOP: begin
                n_top     = rd_data;
                n_cmp_vld = 1'b0;
                n_state   = r_scan ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN: begin
                // issue one read per cycle, fold in the word read the cycle before
                rd_addr   = r_idx;
                n_cmp_vld = 1'b1;
                cmp_a     = rd_data;
                cmp_b     = r_acc;
                if (r_cmp_vld) begin
                    n_acc = lesser;
                end
                if (r_idx == last_addr) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_SCAN_END: begin
                cmp_a   = rd_data;
                cmp_b   = r_acc;
                n_min   = lesser;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out.top_word   = r_top;
                    n_out.min_word   = r_min;
                    n_out.empty_flag = (r_count == '0);
                    n_out.full_flag  = full;
                    n_out.dropped    = r_drop;
                    n_out_vld        = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/mts_checker.sv @@
// Port-level checks for the minimum-tracking stack, bound to the top level.
`timescale 1ns / 1ps

module mts_checker
    import mts_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one item at a time: busy straight after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.empty_flag |->
            o_out_data.top_word == 32'sd0 && o_out_data.min_word == MIN_EMPTY)
        else $error("empty stack shows a top or minimum word");

    a_empty_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.empty_flag && o_out_data.full_flag))
        else $error("stack reported both empty and full");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left a result or a busy sequencer");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);
